### rtl/core/sdsu_pkg.sv
package sdsu_pkg;

   localparam int CHAN_W            = 8;
   localparam int PIX_W             = 3 * CHAN_W;
   localparam int CFG_W             = 12;
   localparam int PCOL_W            = 11;
   localparam int DISP_W            = 8;
   localparam int COST_W            = 2 * CHAN_W + 2;
   localparam int SEARCH_RADIUS_DEF = 11;
   localparam int MAX_WIDTH_DEF     = 2048;
   localparam int QUEUE_DEPTH       = 4;
   localparam logic [CFG_W-1:0] WIDTH_RESET = 12'd640;

   typedef struct packed {
      logic [CHAN_W-1:0] left_red;
      logic [CHAN_W-1:0] left_green;
      logic [CHAN_W-1:0] left_blue;
      logic [CHAN_W-1:0] right_red;
      logic [CHAN_W-1:0] right_green;
      logic [CHAN_W-1:0] right_blue;
   } req_type;

   typedef struct packed {
      logic [DISP_W-1:0] disparity;
      logic [PCOL_W-1:0] pixel_column;
      logic              run_last;
   } rsp_type;

   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
   } pixel_type;

   typedef struct packed {
      logic full;
      logic not_empty;
   } queue_status_type;

   // queue entry: right window, left window, current column, first and last job column
   function automatic int entry_width(input int radius, input int max_width);
      return 3 * radius * PIX_W + 3 * $clog2(max_width);
   endfunction

endpackage

### rtl/core/sdsu_front.sv
module sdsu_front #(
   parameter int SEARCH_RADIUS = sdsu_pkg::SEARCH_RADIUS_DEF,
   parameter int MAX_WIDTH     = sdsu_pkg::MAX_WIDTH_DEF
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  logic [sdsu_pkg::CFG_W-1:0]              csr_data,
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  sdsu_pkg::req_type                       req_data,
   output logic                                    push_valid,
   output logic [sdsu_pkg::entry_width(SEARCH_RADIUS, MAX_WIDTH)-1:0] push_data,
   input  sdsu_pkg::queue_status_type              queue_status
);
   import sdsu_pkg::*;

   localparam int R  = SEARCH_RADIUS;
   localparam int CW = $clog2(MAX_WIDTH);
   localparam int WW = (CFG_W > $clog2(MAX_WIDTH + 1)) ? CFG_W : $clog2(MAX_WIDTH + 1);
   localparam int LOFS = 2 * R * PIX_W;
   localparam int COFS = 3 * R * PIX_W;

   logic [CFG_W-1:0] width_ff;
   logic [CW-1:0]    column_ff;
   logic [CW-1:0]    column_in;
   pixel_type        right_ff [2*R];
   pixel_type        left_ff  [R];

   pixel_type        right_pix;
   pixel_type        left_pix;
   logic             accept;
   logic [WW-1:0]    width_eff;
   logic             row_last;
   logic [CW:0]      col_p1;
   logic             has_job;
   logic [CW-1:0]    first_col;
   logic [CW-1:0]    end_col;

   assign csr_ready = 1'b1;
   assign req_stall = queue_status.full;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      right_pix.red   = req_data.right_red;
      right_pix.green = req_data.right_green;
      right_pix.blue  = req_data.right_blue;
      left_pix.red    = req_data.left_red;
      left_pix.green  = req_data.left_green;
      left_pix.blue   = req_data.left_blue;

      // zero width acts as one, oversize clamps
      width_eff = WW'(width_ff);
      if (width_ff == '0) begin
         width_eff = WW'(1);
      end else if (width_eff > WW'(MAX_WIDTH)) begin
         width_eff = WW'(MAX_WIDTH);
      end
      row_last = WW'(column_ff) >= (width_eff - WW'(1));
      col_p1   = {1'b0, column_ff} + (CW+1)'(1);

      has_job = 1'b1;
      if (col_p1 >= (CW+1)'(R)) begin
         first_col = CW'(col_p1 - (CW+1)'(R));
      end else if (row_last) begin
         first_col = '0;
      end else begin
         first_col = '0;
         has_job   = 1'b0;
      end
      end_col   = row_last ? column_ff : first_col;
      column_in = row_last ? '0 : CW'(col_p1);

      push_valid = accept && has_job;

      // snapshot of the windows after this item is shifted in
      push_data = '0;
      push_data[0 +: PIX_W] = right_pix;
      for (int i = 1; i < 2 * R; i++) begin
         push_data[i*PIX_W +: PIX_W] = right_ff[i-1];
      end
      push_data[LOFS +: PIX_W] = left_pix;
      for (int i = 1; i < R; i++) begin
         push_data[LOFS + i*PIX_W +: PIX_W] = left_ff[i-1];
      end
      push_data[COFS +: CW]        = column_ff;
      push_data[COFS + CW +: CW]   = first_col;
      push_data[COFS + 2*CW +: CW] = end_col;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         column_ff <= '0;
      end else begin
         if (csr_valid && csr_ready) begin
            width_ff <= csr_data;
         end
         if (accept) begin
            column_ff <= column_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         right_ff[0] <= right_pix;
         for (int i = 1; i < 2 * R; i++) begin
            right_ff[i] <= right_ff[i-1];
         end
         left_ff[0] <= left_pix;
         for (int i = 1; i < R; i++) begin
            left_ff[i] <= left_ff[i-1];
         end
      end
   end

endmodule

### rtl/core/sdsu_queue.sv
module sdsu_queue #(
   parameter int DATA_W = 1,
   parameter int DEPTH  = sdsu_pkg::QUEUE_DEPTH
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push_valid,
   input  logic [DATA_W-1:0]          push_data,
   input  logic                       pop,
   output sdsu_pkg::queue_status_type status,
   output logic [DATA_W-1:0]          head_data
);
   import sdsu_pkg::*;

   localparam int PW = $clog2(DEPTH);
   localparam int NW = $clog2(DEPTH + 1);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [PW-1:0]     wr_ptr_ff;
   logic [PW-1:0]     rd_ptr_ff;
   logic [NW-1:0]     count_ff;
   logic [PW-1:0]     wr_ptr_in;
   logic [PW-1:0]     rd_ptr_in;
   logic [NW-1:0]     count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_valid) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (push_valid && !pop) begin
         count_in = count_ff + NW'(1);
      end else if (pop && !push_valid) begin
         count_in = count_ff - NW'(1);
      end
      status.full      = count_ff == NW'(DEPTH);
      status.not_empty = count_ff != '0;
      head_data        = mem_ff[rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### rtl/core/sdsu_back.sv
module sdsu_back #(
   parameter int SEARCH_RADIUS = sdsu_pkg::SEARCH_RADIUS_DEF,
   parameter int MAX_WIDTH     = sdsu_pkg::MAX_WIDTH_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  sdsu_pkg::queue_status_type queue_status,
   input  logic [sdsu_pkg::entry_width(SEARCH_RADIUS, MAX_WIDTH)-1:0] head_data,
   output logic                       pop,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output sdsu_pkg::rsp_type          rsp_data
);
   import sdsu_pkg::*;

   localparam int R    = SEARCH_RADIUS;
   localparam int CW   = $clog2(MAX_WIDTH);
   localparam int NL   = 2 * R;
   localparam int IW   = $clog2(NL);
   localparam int P    = 2 ** IW;
   localparam int MD   = 4 + IW;
   localparam int LOFS = 2 * R * PIX_W;
   localparam int COFS = 3 * R * PIX_W;

   function automatic logic [CHAN_W-1:0] abs_diff(input logic [CHAN_W-1:0] a,
                                                  input logic [CHAN_W-1:0] b);
      return (a > b) ? (a - b) : (b - a);
   endfunction

   // head entry fields
   pixel_type     head_right [NL];
   pixel_type     head_left  [R];
   logic [CW-1:0] head_col;
   logic [CW-1:0] head_first;
   logic [CW-1:0] head_end;

   // job sequencer
   logic [CW-1:0] off_ff;
   logic [CW-1:0] job_col;
   logic          job_end;
   logic [CW-1:0] d_full;
   logic [IW-1:0] job_d;
   logic [CW:0]   d_plus;
   logic [CW:0]   lim_full;
   logic [IW-1:0] job_lim;
   pixel_type     job_left;
   logic          issue;
   logic          adv;

   // lane stages
   pixel_type           rw1_ff [NL];
   pixel_type           lp1_ff;
   logic [IW-1:0]       lim1_ff;
   logic [CHAN_W-1:0]   dr2_ff [NL];
   logic [CHAN_W-1:0]   dg2_ff [NL];
   logic [CHAN_W-1:0]   db2_ff [NL];
   logic [NL-1:0]       v2_ff;
   logic [2*CHAN_W-1:0] sr3_ff [NL];
   logic [2*CHAN_W-1:0] sg3_ff [NL];
   logic [2*CHAN_W-1:0] sb3_ff [NL];
   logic [NL-1:0]       v3_ff;

   // min tree in heap order, leaves at P..2P-1
   logic [COST_W-1:0]   cost_ff [1:2*P-1];
   logic [IW-1:0]       idx_ff  [1:2*P-1];
   logic [2*P-1:1]      nv_ff;
   logic [P-1:1]        pick_hi;

   // job tags traveling with the lanes
   logic [MD-1:0]       mv_ff;
   logic [IW-1:0]       md_ff   [MD];
   logic [CW-1:0]       mcol_ff [MD];
   logic [MD-1:0]       mlast_ff;

   rsp_type             rsp_data_ff;
   logic                rsp_valid_ff;

   assign adv       = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      for (int i = 0; i < NL; i++) begin
         head_right[i] = pixel_type'(head_data[i*PIX_W +: PIX_W]);
      end
      for (int i = 0; i < R; i++) begin
         head_left[i] = pixel_type'(head_data[LOFS + i*PIX_W +: PIX_W]);
      end
      head_col   = head_data[COFS +: CW];
      head_first = head_data[COFS + CW +: CW];
      head_end   = head_data[COFS + 2*CW +: CW];

      job_col = head_first + off_ff;
      job_end = job_col == head_end;
      issue   = queue_status.not_empty && adv;
      pop     = issue && job_end;

      // distance back to the left pixel, and last usable window tap
      d_full = head_col - job_col;
      job_d  = IW'(d_full);
      d_plus = {1'b0, d_full} + (CW+1)'(R);
      lim_full = ({1'b0, head_col} < d_plus) ? {1'b0, head_col} : d_plus;
      job_lim  = IW'(lim_full);

      job_left = head_left[0];
      for (int k = 1; k < R; k++) begin
         if (job_d == IW'(k)) begin
            job_left = head_left[k];
         end
      end

      // on equal cost the higher tap (smaller column) wins
      for (int k = 1; k < P; k++) begin
         pick_hi[k] = nv_ff[2*k+1] && (!nv_ff[2*k] || (cost_ff[2*k+1] <= cost_ff[2*k]));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         off_ff       <= '0;
         mv_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         if (pop) begin
            off_ff <= '0;
         end else if (issue) begin
            off_ff <= off_ff + CW'(1);
         end
         mv_ff        <= {mv_ff[MD-2:0], issue};
         rsp_valid_ff <= mv_ff[MD-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < NL; i++) begin
            rw1_ff[i] <= head_right[i];
         end
         lp1_ff  <= job_left;
         lim1_ff <= job_lim;

         for (int i = 0; i < NL; i++) begin
            dr2_ff[i] <= abs_diff(rw1_ff[i].red, lp1_ff.red);
            dg2_ff[i] <= abs_diff(rw1_ff[i].green, lp1_ff.green);
            db2_ff[i] <= abs_diff(rw1_ff[i].blue, lp1_ff.blue);
            v2_ff[i]  <= IW'(i) <= lim1_ff;
         end

         for (int i = 0; i < NL; i++) begin
            sr3_ff[i] <= (2*CHAN_W)'(dr2_ff[i]) * (2*CHAN_W)'(dr2_ff[i]);
            sg3_ff[i] <= (2*CHAN_W)'(dg2_ff[i]) * (2*CHAN_W)'(dg2_ff[i]);
            sb3_ff[i] <= (2*CHAN_W)'(db2_ff[i]) * (2*CHAN_W)'(db2_ff[i]);
         end
         v3_ff <= v2_ff;

         for (int i = 0; i < NL; i++) begin
            cost_ff[P+i] <= COST_W'(sr3_ff[i]) + COST_W'(sg3_ff[i]) + COST_W'(sb3_ff[i]);
            idx_ff[P+i]  <= IW'(i);
            nv_ff[P+i]   <= v3_ff[i];
         end
         for (int i = NL; i < P; i++) begin
            cost_ff[P+i] <= '0;
            idx_ff[P+i]  <= IW'(i);
            nv_ff[P+i]   <= 1'b0;
         end

         for (int k = 1; k < P; k++) begin
            cost_ff[k] <= pick_hi[k] ? cost_ff[2*k+1] : cost_ff[2*k];
            idx_ff[k]  <= pick_hi[k] ? idx_ff[2*k+1]  : idx_ff[2*k];
            nv_ff[k]   <= nv_ff[2*k+1] || nv_ff[2*k];
         end

         md_ff[0]    <= job_d;
         mcol_ff[0]  <= job_col;
         mlast_ff[0] <= job_end;
         for (int k = 1; k < MD; k++) begin
            md_ff[k]    <= md_ff[k-1];
            mcol_ff[k]  <= mcol_ff[k-1];
            mlast_ff[k] <= mlast_ff[k-1];
         end

         rsp_data_ff.disparity    <= DISP_W'(md_ff[MD-1]) - DISP_W'(idx_ff[1]);
         rsp_data_ff.pixel_column <= PCOL_W'(mcol_ff[MD-1]);
         rsp_data_ff.run_last     <= mlast_ff[MD-1];
      end
   end

endmodule

### rtl/core/stereo_disparity_search_unit.sv
// throughput: one item per cycle while the queue is not full; the back end retires one
// result per cycle unless rsp_stall holds it, so a row-end item with n results holds
// the back end while they issue, and the queue absorbs input until it fills
// reset: synchronous, active high; clears column counter, queue and pipeline valids,
// image_width returns to 640; window contents are not cleared
module stereo_disparity_search_unit #(
   parameter int SEARCH_RADIUS = sdsu_pkg::SEARCH_RADIUS_DEF,
   parameter int MAX_WIDTH     = sdsu_pkg::MAX_WIDTH_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   // image width register
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [sdsu_pkg::CFG_W-1:0] csr_data,
   // pixel pair items in
   input  logic                       req_valid,
   output logic                       req_stall,
   input  sdsu_pkg::req_type          req_data,
   // disparity items out
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output sdsu_pkg::rsp_type          rsp_data
);
   import sdsu_pkg::*;

   localparam int EW = entry_width(SEARCH_RADIUS, MAX_WIDTH);

   // front -> queue: one entry per item that releases results,
   // holding a snapshot of both windows and the job column range
   logic             push_valid;
   logic [EW-1:0]    push_data;
   // queue -> back: head entry, popped when its last job issues
   logic [EW-1:0]    head_data;
   logic             pop;
   queue_status_type q_status;

   // front: width register, column counter, window shift lines, job classification
   sdsu_front #(
      .SEARCH_RADIUS (SEARCH_RADIUS),
      .MAX_WIDTH     (MAX_WIDTH)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_data     (csr_data),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_data     (req_data),
      .push_valid   (push_valid),
      .push_data    (push_data),
      .queue_status (q_status)
   );

   // short decoupling queue
   sdsu_queue #(
      .DATA_W (EW),
      .DEPTH  (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .pop        (pop),
      .status     (q_status),
      .head_data  (head_data)
   );

   // back: job sequencer, cost lanes, registered min tree, output register
   sdsu_back #(
      .SEARCH_RADIUS (SEARCH_RADIUS),
      .MAX_WIDTH     (MAX_WIDTH)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .queue_status (q_status),
      .head_data    (head_data),
      .pop          (pop),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_data     (rsp_data)
   );

   // front never writes into a full queue
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      push_valid |-> !q_status.full)
      else $error("item pushed into full queue");

   // back only retires an entry that exists
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      pop |-> q_status.not_empty)
      else $error("pop from empty queue");

   // after a push the queue reports not empty on the next cycle
   a_push_visible: assert property (@(posedge clock) disable iff (reset)
      push_valid |=> q_status.not_empty)
      else $error("pushed entry lost");

endmodule

### tb/stereo_disparity_search_unit_tb.sv
module stereo_disparity_search_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import sdsu_pkg::*;

   // search geometry of the block under test
   localparam int RADIUS        = SEARCH_RADIUS_DEF;
   localparam int WINDOW        = 2 * RADIUS;
   localparam int WIDTH_MAX     = MAX_WIDTH_DEF;
   // settle margin that covers the pipeline depth, so anything still in flight drains
   localparam int SETTLE_CYCLES = 24;
   localparam int RANDOM_ITEMS  = 300;
   localparam int CYCLE_LIMIT   = 1_000_000;
   localparam int REPORT_MAX    = 10;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic [CFG_W-1:0]    csr_data = '0;
   logic                req_valid = 1'b0;
   logic                req_stall;
   req_type             req_data = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   rsp_type             rsp_data;

   // shadow of the block: window contents, column position and width setting
   pixel_type           right_hist [WINDOW];
   pixel_type           left_hist  [RADIUS];
   int                  next_column;
   logic [CFG_W-1:0]    width_setting;

   // disparities predicted but not yet seen on the output
   rsp_type             pending_disparities [$];

   // per-phase test scene, used to build shifted left/right rows
   pixel_type           scene [64];

   bit                  req_gaps_on = 1'b0;
   bit                  rsp_gaps_on = 1'b0;
   int                  stall_hold = 0;
   int                  mismatch_count = 0;
   int                  cycle_count = 0;

   stereo_disparity_search_unit u_dut (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // 12 ns clock
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // idle stretch length: mostly none, some short, a few long
   function automatic int idle_length();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 88) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 50);
   endfunction

   // coarse pixels use only a few levels, so equal costs come up often
   function automatic pixel_type random_pixel(bit coarse);
      pixel_type p;
      logic [7:0] levels [3];
      levels = '{8'h00, 8'h80, 8'hff};
      if (coarse) begin
         p.red   = levels[$urandom_range(0, 2)];
         p.green = levels[$urandom_range(0, 2)];
         p.blue  = levels[$urandom_range(0, 2)];
      end else begin
         p = pixel_type'(PIX_W'($urandom_range(0, 32'h00ff_ffff)));
      end
      return p;
   endfunction

   // squared color distance summed over the three channels
   function automatic int unsigned color_cost(pixel_type a, pixel_type b);
      int dr, dg, db;
      dr = int'(a.red) - int'(b.red);
      dg = int'(a.green) - int'(b.green);
      db = int'(a.blue) - int'(b.blue);
      return dr * dr + dg * dg + db * db;
   endfunction

   // best match for column j while the window ends at column c
   function automatic logic [DISP_W-1:0] best_disparity(int j, int c);
      pixel_type   left_pix;
      int          best_col;
      int unsigned best_cost;
      int unsigned cost;
      int          start;
      left_pix  = left_hist[c - j];
      start     = (j >= RADIUS) ? j - RADIUS : 0;
      best_col  = start;
      best_cost = 32'hffff_ffff;
      // strict compare keeps the leftmost column on a tie
      for (int k = start; k <= c; k++) begin
         cost = color_cost(left_pix, right_hist[c - k]);
         if (cost < best_cost) begin
            best_cost = cost;
            best_col  = k;
         end
      end
      return DISP_W'(best_col - j);
   endfunction

   // advance the shadow by one accepted item and queue the disparities it releases
   task automatic predict_pixel_pair(req_type item);
      int      w, c, first, last_col;
      bit      row_end;
      rsp_type e;
      w = int'(width_setting);
      // zero width acts as one, oversized widths clamp to the maximum
      if (w == 0) w = 1;
      if (w > WIDTH_MAX) w = WIDTH_MAX;
      for (int i = WINDOW - 1; i > 0; i--) right_hist[i] = right_hist[i-1];
      right_hist[0] = {item.right_red, item.right_green, item.right_blue};
      for (int i = RADIUS - 1; i > 0; i--) left_hist[i] = left_hist[i-1];
      left_hist[0] = {item.left_red, item.left_green, item.left_blue};
      c = next_column;
      // row also ends here when the width shrank below the current column
      row_end = (c >= w - 1);
      if (c + 1 >= RADIUS) first = c + 1 - RADIUS;
      else if (row_end) first = 0;
      else first = c + 1;
      if (first <= c) begin
         // row end flushes every column still waiting
         last_col = row_end ? c : first;
         for (int j = first; j <= last_col; j++) begin
            e.disparity    = best_disparity(j, c);
            e.pixel_column = PCOL_W'(j);
            e.run_last     = (j == last_col);
            pending_disparities.push_back(e);
         end
      end
      next_column = row_end ? 0 : c + 1;
   endtask

   task automatic log_mismatch(string what);
      mismatch_count++;
      if (mismatch_count <= REPORT_MAX) $display("%0t ns: %s", $time, what);
   endtask

   // result side: random stall pattern and the compare against the oldest prediction
   always @(posedge clock) begin
      rsp_type got, want;
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_hold <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got = rsp_data;
            if (pending_disparities.size() == 0) begin
               log_mismatch($sformatf("unexpected item: disparity %0d column %0d last %0b",
                                      got.disparity, got.pixel_column, got.run_last));
            end else begin
               want = pending_disparities.pop_front();
               if (got.disparity !== want.disparity || got.pixel_column !== want.pixel_column
                   || got.run_last !== want.run_last) begin
                  log_mismatch($sformatf({"column %0d: expected disparity %0d column %0d ",
                                          "last %0b, got disparity %0d column %0d last %0b"},
                                         want.pixel_column, want.disparity, want.pixel_column,
                                         want.run_last, got.disparity, got.pixel_column,
                                         got.run_last));
               end
            end
         end
         if (stall_hold > 0) begin
            stall_hold <= stall_hold - 1;
         end else if (rsp_gaps_on && $urandom_range(0, 2) == 0) begin
            rsp_stall  <= 1'b1;
            stall_hold <= idle_length();
         end else begin
            rsp_stall  <= 1'b0;
            stall_hold <= $urandom_range(0, 4);
         end
      end
   end

   // hard stop if the block hangs
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // offer one item, hold it until taken, then maybe go quiet for a while
   task automatic send_pixel_pair(req_type item);
      int gap;
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_pixel_pair(item);
      gap = req_gaps_on ? idle_length() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // sender holds off until every predicted item is out and the pipe is empty
   task automatic wait_for_results();
      req_valid <= 1'b0;
      while (pending_disparities.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // width register is only touched while the block is idle
   task automatic set_image_width(logic [CFG_W-1:0] value);
      wait_for_results();
      csr_valid <= 1'b1;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid     <= 1'b0;
      width_setting  = value;
   endtask

   // reset width, channel extremes and ties, then a shrink that flushes a full window
   task automatic test_reset_width_flush();
      req_gaps_on = 1'b0;
      rsp_gaps_on = 1'b0;
      send_pixel_pair({24'h000000, 24'h000000});
      send_pixel_pair({24'hffffff, 24'hffffff});
      send_pixel_pair({24'h000000, 24'hffffff});
      send_pixel_pair({24'hffffff, 24'h000000});
      send_pixel_pair({24'haaaaaa, 24'h555555});
      send_pixel_pair({24'h555555, 24'haaaaaa});
      // identical pixels give equal costs, leftmost column must win
      repeat (6) send_pixel_pair({24'h808080, 24'h808080});
      // column 12 is past the end of a 3 wide row, so this item flushes 11 columns
      set_image_width(12'd3);
      send_pixel_pair({24'h123456, 24'h654321});
   endtask

   // zero width acts as one pixel per row, then a row narrower than the radius
   task automatic test_narrow_rows();
      req_gaps_on = 1'b1;
      rsp_gaps_on = 1'b1;
      set_image_width(12'd0);
      repeat (2) send_pixel_pair({random_pixel(1'b0), random_pixel(1'b0)});
      set_image_width(12'd3);
      repeat (3) send_pixel_pair({random_pixel(1'b0), random_pixel(1'b0)});
   endtask

   // a width above the maximum clamps, then the maximum itself, then a drop to one pixel ends the row mid-way
   task automatic test_oversize_width();
      set_image_width(12'hfff);
      repeat (5) send_pixel_pair({random_pixel(1'b0), random_pixel(1'b0)});
      set_image_width(12'd2048);
      repeat (6) send_pixel_pair({random_pixel(1'b0), random_pixel(1'b0)});
      set_image_width(12'd1);
      send_pixel_pair({random_pixel(1'b1), random_pixel(1'b1)});
   endtask

   // random widths, mostly whole rows of shifted scenes, some noise and ragged row ends
   task automatic test_random_rows();
      int        sent, w, count, shift, flavor, pick;
      pixel_type lp, rp;
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         pick = $urandom_range(0, 9);
         case (pick)
            0: begin
               w = 1;
            end
            1: begin
               w = 2;
            end
            2: begin
               w = RADIUS - 1;
            end
            3: begin
               w = RADIUS;
            end
            4: begin
               w = RADIUS + 1;
            end
            5: begin
               w = $urandom_range(3, 9);
            end
            default: begin
               w = $urandom_range(12, 48);
            end
         endcase
         // a ragged tail leaves the next width change landing mid-row
         count = $urandom_range(1, 3) * w;
         if ($urandom_range(0, 3) == 0) count += $urandom_range(1, w);
         // the last phase stops at the item budget
         if (count > RANDOM_ITEMS - sent) count = RANDOM_ITEMS - sent;
         // flavor 0: pure noise, 1: shifted scene, 2: coarse scene with ties, 3: noisy shift
         flavor = $urandom_range(0, 3);
         shift  = $urandom_range(0, 2 * RADIUS) - RADIUS;
         for (int i = 0; i < 64; i++) scene[i] = random_pixel(flavor == 2);
         set_image_width(CFG_W'(w));
         // some phases run with no idling on one or both sides
         req_gaps_on = ($urandom_range(0, 3) != 0);
         rsp_gaps_on = ($urandom_range(0, 3) != 0);
         repeat (count) begin
            if (flavor == 0) begin
               lp = random_pixel(1'b0);
               rp = random_pixel(1'b0);
            end else begin
               lp = scene[next_column & 63];
               rp = scene[(next_column + shift) & 63];
               if (flavor == 3) begin
                  rp.red  = rp.red ^ 8'($urandom_range(0, 7));
                  rp.blue = rp.blue ^ 8'($urandom_range(0, 7));
               end
            end
            send_pixel_pair({lp, rp});
            sent++;
         end
      end
   endtask

   initial begin
      // shadow starts from the reset state
      foreach (right_hist[i]) right_hist[i] = '0;
      foreach (left_hist[i]) left_hist[i] = '0;
      next_column   = 0;
      width_setting = WIDTH_RESET;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      test_reset_width_flush();
      test_narrow_rows();
      test_oversize_width();
      test_random_rows();

      wait_for_results();
      if (mismatch_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

### stereo_disparity_search_unit.f
rtl/core/sdsu_pkg.sv
rtl/core/sdsu_front.sv
rtl/core/sdsu_queue.sv
rtl/core/sdsu_back.sv
rtl/core/stereo_disparity_search_unit.sv
tb/stereo_disparity_search_unit_tb.sv
